### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nshf_pkg.sv
// Package of the NMEA sentence header filter: constants, register indexes and
// the command and status types between controller and datapath. No dependencies.
package nshf_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int HDR_LEN      = 5;
   localparam int HEADER_SPAN  = 6;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 8;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [CSR_ADDR_W-1:0] CSR_HDR_ONE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HDR_TWO   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HDR_THREE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HDR_FOUR  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_HDR_FIVE  = 3'd4;

   localparam logic [7:0] HDR_RESET [HDR_LEN] = '{8'd71, 8'd80, 8'd82, 8'd77, 8'd67};

   typedef struct packed {
      logic capture;
      logic load_rd;
      logic issue;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic is_dollar;
      logic is_cr;
      logic rd_last;
      logic slot_free;
   } sts_type;

endpackage

### rtl/nshf_ctrl.sv
// Controller of the NMEA sentence header filter: accept and emit state machine.
// Depends on nshf_pkg; drives the commands of nshf_dp from its status.
module nshf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  nshf_pkg::sts_type sts,
   output nshf_pkg::cmd_type cmd
);
   import nshf_pkg::*;

   typedef enum logic {
      ST_ACCEPT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_tready_ff;
   logic      take;

   assign req_tready = req_tready_ff;
   assign take       = req_tvalid && req_tready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_ACCEPT: begin
            if (take) begin
               if (sts.active && sts.is_cr) begin
                  cmd.load_rd = 1'b1;
                  state_in    = ST_EMIT;
               end else if (sts.active || sts.is_dollar) begin
                  cmd.capture = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               cmd.issue = 1'b1;
               if (sts.rd_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_ACCEPT;
               end
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ACCEPT;
         req_tready_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         req_tready_ff <= (state_in == ST_ACCEPT);
      end
   end

endmodule

### rtl/nshf_dp.sv
// Datapath of the NMEA sentence header filter: header registers, line memory,
// capture counters and the result register. Depends on nshf_pkg.
module nshf_dp #(
   parameter int CAPACITY = nshf_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_tdata,
   input  logic                              csr_we,
   input  logic [nshf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [nshf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  nshf_pkg::cmd_type                 cmd,
   output nshf_pkg::sts_type                 sts,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser
);
   import nshf_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic [7:0]       hdr_ff [HDR_LEN];
   logic [7:0]       mem [CAPACITY];
   logic [CNT_W-1:0] count_ff;
   logic             mism_ff;
   logic             drop_ff;
   logic [IDX_W-1:0] rd_ptr_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_last_ff;
   logic             rsp_ovf_ff;

   logic             full;
   logic             hdr_miss;
   logic             miss_in;
   logic             abandon;

   assign full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      hdr_miss = 1'b0;
      for (int i = 0; i < HDR_LEN; i++) begin
         if (count_ff == CNT_W'(i + 1) && req_tdata != hdr_ff[i]) begin
            hdr_miss = 1'b1;
         end
      end
   end

   assign miss_in = mism_ff || hdr_miss;
   assign abandon = (count_ff == CNT_W'(HEADER_SPAN - 1)) && miss_in;

   assign sts.active    = (count_ff != '0);
   assign sts.is_dollar = (req_tdata == CH_DOLLAR);
   assign sts.is_cr     = (req_tdata == CH_CR);
   assign sts.rd_last   = ((CNT_W'(rd_ptr_ff) + CNT_W'(1)) == count_ff);
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HDR_LEN; i++) begin
            hdr_ff[i] <= HDR_RESET[i];
         end
         count_ff     <= '0;
         mism_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_HDR_ONE:   hdr_ff[0] <= csr_wdata;
               CSR_HDR_TWO:   hdr_ff[1] <= csr_wdata;
               CSR_HDR_THREE: hdr_ff[2] <= csr_wdata;
               CSR_HDR_FOUR:  hdr_ff[3] <= csr_wdata;
               CSR_HDR_FIVE:  hdr_ff[4] <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.capture) begin
            if (abandon) begin
               count_ff <= '0;
               mism_ff  <= 1'b0;
               drop_ff  <= 1'b0;
            end else begin
               mism_ff <= miss_in;
               if (full) begin
                  drop_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
         end
         if (cmd.clear) begin
            count_ff <= '0;
            mism_ff  <= 1'b0;
            drop_ff  <= 1'b0;
         end
         if (cmd.load_rd) begin
            rd_ptr_ff <= '0;
         end else if (cmd.issue) begin
            rd_ptr_ff <= rd_ptr_ff + IDX_W'(1);
         end
         if (cmd.issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && !full) begin
         mem[count_ff[IDX_W-1:0]] <= req_tdata;
      end
      if (cmd.issue) begin
         rsp_data_ff <= mem[rd_ptr_ff];
         rsp_last_ff <= sts.rd_last;
         rsp_ovf_ff  <= drop_ff;
      end
   end

endmodule

### rtl/nmea_sentence_header_filter.sv
// Top level of the NMEA sentence header filter.
// Depends on nshf_pkg, nshf_ctrl and nshf_dp.
//
// The req_ channel takes one received byte per transaction. Outside a sentence
// every byte but '$' is dropped; a '$' opens capture into a line memory of
// CAPACITY bytes. Positions 1 to 5 are compared with the five header
// characters written through the csr_ port (index 0 to 4); on a mismatch the
// capture is abandoned at the sixth byte. A carriage return closes the capture
// and the stored sentence leaves on the rsp_ channel, one byte per
// transaction, with rsp_tlast on the final byte and rsp_tuser set on every
// byte when bytes beyond capacity were dropped.
// Throughput: one input byte per cycle outside the emit state. A carriage
// return holds req_tready low while the stored bytes are read through the
// line memory's one read port; rsp_tvalid rises when the emit state issues
// the first byte. The result register lets the next sentence start while
// the final byte still waits. When the receiver stalls, the output holds
// and reading of the line memory pauses. Synchronous reset restores the
// default header "GPRMC", ends any capture and empties the result register.
module nmea_sentence_header_filter #(
   parameter int CAPACITY = nshf_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] sentence_byte
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,   // [0] overflowed
   input  logic                            csr_we,
   input  logic [nshf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [nshf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nshf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   nshf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   nshf_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/nshf_checker.sv
// Port-level checker of the NMEA sentence header filter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module nshf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   `CHK_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "Stalled result changed")

   `CHK_ASSERT(a_no_input_mid_run, clock, reset,
      rsp_tvalid && !rsp_tlast |-> !req_tready,
      "Input taken while a sentence is being sent")

   `CHK_ASSERT(a_run_continues, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser),
      "Sentence run broken or overflow flag changed")

   `CHK_ASSERT_ALWAYS(a_reset_quiet, clock,
      reset |=> !rsp_tvalid && !req_tready,
      "Channels active right after reset")

endmodule

bind nmea_sentence_header_filter nshf_checker u_nshf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

### sim/tb_top.sv
// Self-checking testbench for nmea_sentence_header_filter: drives bytes on req_,
// checks the emitted sentences on rsp_ and rewrites the header through csr_.
// Depends on nshf_pkg and the RTL of the block.
module tb_top;
   import nshf_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PHASE_BYTES    = 25;
   localparam int IDLE_LOW       = 24;
   localparam int IDLE_HIGH      = 60;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       overflowed;
   } sentence_byte_type;

   class sentence_scoreboard;
      logic [7:0]        header [HDR_LEN];
      logic [7:0]        line_buf [CAPACITY_DEF];
      int unsigned       fill_cnt;
      int unsigned       match_cnt;
      bit                dropped;
      sentence_byte_type expected_q [$];
      int unsigned       mismatches;

      function new();
         header     = HDR_RESET;
         fill_cnt   = 0;
         match_cnt  = 0;
         dropped    = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [7:0] val);
         if (idx <= CSR_HDR_FIVE) begin
            header[idx] = val;
         end
      endfunction

      // Returns 1 when the byte was taken into a sentence rather than ignored.
      function bit note_input(logic [7:0] b);
         int unsigned pos;
         if (fill_cnt == 0 && b != CH_DOLLAR) begin
            return 0;
         end
         if (fill_cnt > 0 && b == CH_CR) begin
            for (int unsigned k = 0; k < fill_cnt; k++) begin
               expected_q.push_back('{line_buf[k], k + 1 == fill_cnt, dropped});
            end
            fill_cnt  = 0;
            match_cnt = 0;
            dropped   = 0;
            return 1;
         end
         pos = fill_cnt;
         if (pos < CAPACITY_DEF) begin
            line_buf[pos] = b;
            fill_cnt      = pos + 1;
         end else begin
            dropped = 1;
         end
         if (pos == 0) begin
            match_cnt++;
         end else if (pos < HEADER_SPAN && b == header[pos - 1]) begin
            match_cnt++;
         end
         if (pos + 1 == HEADER_SPAN && match_cnt < HEADER_SPAN) begin
            fill_cnt  = 0;
            match_cnt = 0;
            dropped   = 0;
         end
         return 1;
      endfunction

      function void check_result(logic [7:0] data, logic last, logic overflowed);
         sentence_byte_type exp_byte;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected byte %h last %b overflowed %b",
                        data, last, overflowed);
            end
            return;
         end
         exp_byte = expected_q.pop_front();
         if (exp_byte.data !== data || exp_byte.last !== last ||
             exp_byte.overflowed !== overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: expected byte %h last %b overflowed %b, got %h %b %b",
                        exp_byte.data, exp_byte.last, exp_byte.overflowed,
                        data, last, overflowed);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   sentence_scoreboard sb = new();
   int unsigned send_idle   = IDLE_LOW;
   int unsigned recv_idle   = IDLE_HIGH;
   int unsigned taken_bytes = 0;
   int unsigned idle_cycles = 0;

   nmea_sentence_header_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
         rsp_tready  <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (sb.note_input(b)) begin
         taken_bytes++;
      end
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   task automatic send_sentence();
      int unsigned bad_pos;
      int unsigned body_len;
      logic [7:0]  hdr_byte;
      bad_pos  = ($urandom_range(99) < 15) ? $urandom_range(1, HDR_LEN) : 0;
      body_len = ($urandom_range(99) < 15) ? $urandom_range(55, 70) : $urandom_range(0, 20);
      send_byte(CH_DOLLAR);
      for (int unsigned i = 1; i <= HDR_LEN; i++) begin
         hdr_byte = sb.header[i - 1];
         if (i == bad_pos) begin
            hdr_byte ^= 8'($urandom_range(1, 255));
         end
         send_byte(hdr_byte);
      end
      repeat (body_len) send_byte(8'($urandom));
      send_byte(CH_CR);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 0) ? IDLE_LOW : (phase == 1) ? IDLE_HIGH : 0;
         recv_idle = (phase == 0) ? IDLE_HIGH : (phase == 1) ? IDLE_LOW : 0;
         if (phase > 0) begin
            for (int i = 0; i < HDR_LEN; i++) begin
               csr_write(CSR_ADDR_W'(CSR_HDR_ONE + i),
                         (phase == 1) ? 8'hFF : (phase == 2) ? 8'h00 : 8'($urandom));
            end
            if (phase == 3) begin
               for (int i = HDR_LEN; i < (1 << CSR_ADDR_W); i++) begin
                  csr_write(CSR_ADDR_W'(i), 8'($urandom));
               end
            end
            csr_we <= 1'b0;
            @(posedge clock);
         end else begin
            // Idle noise, a dollar inside a sentence, a short unmatched capture,
            // a header mismatch at the last position and a lone dollar.
            send_byte(CH_CR);
            send_byte(8'h00);
            send_string("$GPRMC$");
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(CH_CR);
            send_string("$GX");
            send_byte(CH_CR);
            send_string("$GPRMX");
            send_byte(CH_CR);
            send_byte(CH_DOLLAR);
            send_byte(CH_CR);
         end
         taken_bytes = 0;
         while (taken_bytes < PHASE_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               send_sentence();
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
               send_byte(CH_DOLLAR);
               repeat ($urandom_range(0, 7)) send_byte(8'($urandom));
               send_byte(CH_CR);
            end
         end
         send_byte(CH_CR);
         drain();
      end
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
